/* sv/glp_pkg.sv */
// Shared types, character constants and the decimal accumulate step of the line parser.
`default_nettype none
package glp_pkg;

  localparam int unsigned NUM_BITS       = 31;
  localparam int unsigned REC_FIXED_BITS = 94;
  localparam int unsigned Q_DEPTH        = 4;
  localparam int unsigned Q_PTR_BITS     = 2;

  localparam logic [NUM_BITS-1:0] NUM_MAX = {NUM_BITS{1'b1}};

  localparam logic [7:0] CH_R    = 8'h72;
  localparam logic [7:0] CH_S    = 8'h73;
  localparam logic [7:0] CH_X_UP = 8'h58;
  localparam logic [7:0] CH_X_LO = 8'h78;
  localparam logic [7:0] CH_Y_UP = 8'h59;
  localparam logic [7:0] CH_Y_LO = 8'h79;
  localparam logic [7:0] CH_A    = 8'h41;
  localparam logic [7:0] CH_C    = 8'h43;
  localparam logic [7:0] CH_G    = 8'h47;
  localparam logic [7:0] CH_T    = 8'h54;
  localparam logic [7:0] CH_D    = 8'h44;
  localparam logic [7:0] CH_I    = 8'h49;
  localparam logic [7:0] CH_ZERO = 8'h30;
  localparam logic [7:0] CH_NINE = 8'h39;

  // classified byte as it travels from front to back
  typedef struct packed {
    logic [7:0] ch;
    logic       last;
    logic       live;
    logic       dig;
    logic       xch;
    logic       ych;
    logic       r;
    logic       s;
    logic       allele;
  } cls_t;

  // v*10 + digit, saturating
  function automatic logic [NUM_BITS-1:0] acc_digit(input logic [NUM_BITS-1:0] v,
                                                    input logic [7:0] c);
    logic [NUM_BITS+3:0] n;
    n = ({4'b0, v} << 3) + ({4'b0, v} << 1) + {{(NUM_BITS){1'b0}}, c[3:0]};
    if (n > {4'b0, NUM_MAX}) begin
      acc_digit = NUM_MAX;
    end else begin
      acc_digit = n[NUM_BITS-1:0];
    end
  endfunction

endpackage
`default_nettype wire

/* sv/glp_front.sv */
// Front end: byte classification and per-line byte counting.
`default_nettype none
module glp_front #(
  parameter int unsigned LINE_BYTES = 256
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         s_tvalid,
  output logic              s_tready,
  input  wire logic [7:0]   s_tdata,   // char_code
  input  wire logic         s_tlast,   // line_end
  input  wire logic         q_full,
  output logic              q_push,
  output glp_pkg::cls_t     q_item
);

  localparam int unsigned CW = $clog2(LINE_BYTES + 1);

  logic [CW-1:0] byte_cnt;
  logic          live;

  assign s_tready = !q_full;
  assign q_push   = s_tvalid && s_tready;
  assign live     = byte_cnt < CW'(LINE_BYTES);

  always_comb begin
    q_item.ch     = s_tdata;
    q_item.last   = s_tlast;
    q_item.live   = live;
    q_item.dig    = (s_tdata >= glp_pkg::CH_ZERO) && (s_tdata <= glp_pkg::CH_NINE);
    q_item.xch    = (s_tdata == glp_pkg::CH_X_UP) || (s_tdata == glp_pkg::CH_X_LO);
    q_item.ych    = (s_tdata == glp_pkg::CH_Y_UP) || (s_tdata == glp_pkg::CH_Y_LO);
    q_item.r      = s_tdata == glp_pkg::CH_R;
    q_item.s      = s_tdata == glp_pkg::CH_S;
    q_item.allele = (s_tdata == glp_pkg::CH_A) || (s_tdata == glp_pkg::CH_C) ||
                    (s_tdata == glp_pkg::CH_G) || (s_tdata == glp_pkg::CH_T) ||
                    (s_tdata == glp_pkg::CH_D) || (s_tdata == glp_pkg::CH_I) ||
                    (s_tdata == glp_pkg::CH_ZERO);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_cnt <= '0;
    end else if (q_push) begin
      if (s_tlast) begin
        byte_cnt <= '0;
      end else if (live) begin
        byte_cnt <= byte_cnt + CW'(1);
      end
    end
  end

  assert property (@(posedge clk) disable iff (rst) byte_cnt <= CW'(LINE_BYTES))
    else $error("byte counter past line limit");

endmodule
`default_nettype wire

/* sv/glp_queue.sv */
// Short queue of classified bytes between front and back.
`default_nettype none
module glp_queue (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          push,
  input  wire glp_pkg::cls_t push_item,
  output logic               full,
  input  wire logic          pop,
  output logic               valid,
  output glp_pkg::cls_t      head
);

  localparam int unsigned PW = glp_pkg::Q_PTR_BITS;

  glp_pkg::cls_t mem [glp_pkg::Q_DEPTH];
  logic [PW-1:0] wptr;
  logic [PW-1:0] rptr;
  logic [PW:0]   count;

  assign full  = count == (PW+1)'(glp_pkg::Q_DEPTH);
  assign valid = count != '0;
  assign head  = mem[rptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= wptr + PW'(1);
      end
      if (pop) begin
        rptr <= rptr + PW'(1);
      end
      if (push && !pop) begin
        count <= count + (PW+1)'(1);
      end else if (pop && !push) begin
        count <= count - (PW+1)'(1);
      end
    end
  end

  assert property (@(posedge clk) disable iff (rst) !(push && full) && !(pop && !valid))
    else $error("queue overflow or underflow");

endmodule
`default_nettype wire

/* sv/glp_back.sv */
// Back end: line parse sequencer, record counter and output register.
`default_nettype none
module glp_back #(
  parameter int unsigned COUNT_BITS = 24
) (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      q_valid,
  input  wire glp_pkg::cls_t q_head,
  output logic           q_pop,
  output logic           m_tvalid,
  input  wire logic      m_tready,
  output logic [((glp_pkg::REC_FIXED_BITS + COUNT_BITS + 7) / 8) * 8 - 1:0] m_tdata
);

  localparam int unsigned REC_BITS = glp_pkg::REC_FIXED_BITS + COUNT_BITS;
  localparam int unsigned OUT_W    = ((REC_BITS + 7) / 8) * 8;
  localparam int unsigned NB       = glp_pkg::NUM_BITS;

  localparam logic [3:0] PH_R          = 4'd0;
  localparam logic [3:0] PH_S          = 4'd1;
  localparam logic [3:0] PH_FIRST      = 4'd2;
  localparam logic [3:0] PH_RS         = 4'd3;
  localparam logic [3:0] PH_SKIP_CHROM = 4'd4;
  localparam logic [3:0] PH_CHROM2     = 4'd5;
  localparam logic [3:0] PH_SKIP_POS   = 4'd6;
  localparam logic [3:0] PH_POS        = 4'd7;
  localparam logic [3:0] PH_SKIP_A1    = 4'd8;
  localparam logic [3:0] PH_SKIP_A2    = 4'd9;
  localparam logic [3:0] PH_IDLE       = 4'd10;

  logic [3:0]            phase, phase_next;
  logic                  qual, qual_next;
  logic [NB-1:0]         rs_acc, rs_acc_next;
  logic [7:0]            chrom0, chrom0_next, chrom1, chrom1_next;
  logic [NB-1:0]         pos_acc, pos_acc_next;
  logic [7:0]            al0, al0_next, al1, al1_next;
  logic [COUNT_BITS-1:0] rec_cnt, rec_cnt_next;
  logic                  do_chrom, do_a1, emit;
  logic                  out_valid;
  logic [OUT_W-1:0]      out_data, rec_word;

  assign q_pop    = q_valid && (!out_valid || m_tready);
  assign m_tvalid = out_valid;
  assign m_tdata  = out_data;

  always_comb begin
    phase_next   = phase;
    qual_next    = qual;
    rs_acc_next  = rs_acc;
    chrom0_next  = chrom0;
    chrom1_next  = chrom1;
    pos_acc_next = pos_acc;
    al0_next     = al0;
    al1_next     = al1;
    do_chrom     = 1'b0;
    do_a1        = 1'b0;
    if (q_pop && q_head.live) begin
      case (phase)
        PH_R: begin
          phase_next = q_head.r ? PH_S : PH_IDLE;
        end
        PH_S: begin
          phase_next = q_head.s ? PH_FIRST : PH_IDLE;
        end
        PH_FIRST: begin
          if (q_head.dig) begin
            qual_next   = 1'b1;
            rs_acc_next = glp_pkg::acc_digit('0, q_head.ch);
            phase_next  = PH_RS;
          end else begin
            phase_next = PH_IDLE;
          end
        end
        PH_RS: begin
          if (q_head.dig) begin
            rs_acc_next = glp_pkg::acc_digit(rs_acc, q_head.ch);
          end else begin
            phase_next = PH_SKIP_CHROM;
            do_chrom   = 1'b1;
          end
        end
        PH_SKIP_CHROM: begin
          do_chrom = 1'b1;
        end
        PH_CHROM2: begin
          if (q_head.dig) begin
            chrom1_next = q_head.ch;
          end
          phase_next = PH_SKIP_POS;
        end
        PH_SKIP_POS: begin
          if (q_head.dig) begin
            pos_acc_next = glp_pkg::acc_digit('0, q_head.ch);
            phase_next   = PH_POS;
          end
        end
        PH_POS: begin
          if (q_head.dig) begin
            pos_acc_next = glp_pkg::acc_digit(pos_acc, q_head.ch);
          end else begin
            phase_next = PH_SKIP_A1;
            do_a1      = 1'b1;
          end
        end
        PH_SKIP_A1: begin
          do_a1 = 1'b1;
        end
        PH_SKIP_A2: begin
          if (q_head.allele) begin
            al1_next   = q_head.ch;
            phase_next = PH_IDLE;
          end
        end
        default: begin
        end
      endcase
      if (do_chrom) begin
        if (q_head.dig) begin
          chrom0_next = q_head.ch;
          phase_next  = PH_CHROM2;
        end else if (q_head.xch) begin
          chrom0_next = glp_pkg::CH_X_UP;
          phase_next  = PH_SKIP_POS;
        end else if (q_head.ych) begin
          chrom0_next = glp_pkg::CH_Y_UP;
          phase_next  = PH_SKIP_POS;
        end
      end
      if (do_a1 && q_head.allele) begin
        al0_next   = q_head.ch;
        phase_next = PH_SKIP_A2;
      end
    end
  end

  assign emit         = q_pop && q_head.last && qual_next;
  assign rec_cnt_next = (rec_cnt == {COUNT_BITS{1'b1}}) ? rec_cnt : rec_cnt + COUNT_BITS'(1);

  always_comb begin
    rec_word = '0;
    rec_word[REC_BITS-1:0] = {rec_cnt_next, al1_next, al0_next, pos_acc_next,
                              chrom1_next, chrom0_next, rs_acc_next};
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_data <= rec_word;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= PH_R;
      qual      <= 1'b0;
      rs_acc    <= '0;
      chrom0    <= '0;
      chrom1    <= '0;
      pos_acc   <= '0;
      al0       <= '0;
      al1       <= '0;
      rec_cnt   <= '0;
      out_valid <= 1'b0;
    end else begin
      if (emit) begin
        out_valid <= 1'b1;
        rec_cnt   <= rec_cnt_next;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
      if (q_pop && q_head.last) begin
        phase   <= PH_R;
        qual    <= 1'b0;
        rs_acc  <= '0;
        chrom0  <= '0;
        chrom1  <= '0;
        pos_acc <= '0;
        al0     <= '0;
        al1     <= '0;
      end else begin
        phase   <= phase_next;
        qual    <= qual_next;
        rs_acc  <= rs_acc_next;
        chrom0  <= chrom0_next;
        chrom1  <= chrom1_next;
        pos_acc <= pos_acc_next;
        al0     <= al0_next;
        al1     <= al1_next;
      end
    end
  end

  assert property (@(posedge clk) disable iff (rst) emit |-> (!out_valid || m_tready))
    else $error("record overwrites an unaccepted record");

  assert property (@(posedge clk) disable iff (rst) out_valid |-> rec_cnt != '0)
    else $error("record pending with zero record count");

  assert property (@(posedge clk) disable iff (rst)
                   (qual && phase == PH_R) |-> 1'b0)
    else $error("qualified line back at line start");

endmodule
`default_nettype wire

/* sv/genotype_line_parser_unit.sv */
// Top level of the genotype text line parser.
// Takes one text byte per cycle on s_* (tlast marks a line's last byte) and sustains
// one byte per clock back to back. A byte is classified in the front end, goes through
// a four-entry queue and is consumed by the parse sequencer, which writes a record into
// the m_* output register as it takes the byte that closes its line. The only throttle is
// the output register: while a record waits for m_tready the queue absorbs up to four
// more bytes, after which s_tready drops. One record per line that starts with "rs" and a
// digit; record_index counts records and saturates at 2^COUNT_BITS-1.
`default_nettype none
module genotype_line_parser_unit #(
  parameter int unsigned LINE_BYTES = 256,
  parameter int unsigned COUNT_BITS = 24
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,   // char_code
  input  wire logic        s_tlast,   // line_end
  output logic             m_tvalid,
  input  wire logic        m_tready,
  // rs_number, chrom_first, chrom_second, position, allele_first, allele_second,
  // record_index, zero fill
  output logic [((glp_pkg::REC_FIXED_BITS + COUNT_BITS + 7) / 8) * 8 - 1:0] m_tdata
);

  glp_pkg::cls_t push_item;
  glp_pkg::cls_t head;
  logic          push, full, pop, q_valid;

  glp_front #(
    .LINE_BYTES(LINE_BYTES)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .q_full   (full),
    .q_push   (push),
    .q_item   (push_item)
  );

  glp_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .full      (full),
    .pop       (pop),
    .valid     (q_valid),
    .head      (head)
  );

  glp_back #(
    .COUNT_BITS(COUNT_BITS)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .q_valid  (q_valid),
    .q_head   (head),
    .q_pop    (pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

endmodule
`default_nettype wire

/* tb/genotype_line_parser_unit_tb.sv */
// Self-checking testbench for the genotype line parser: random text lines, stalls, record checks.
`default_nettype none
module genotype_line_parser_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned LINE_BYTES = 256;
  localparam int unsigned COUNT_BITS = 24;
  localparam int unsigned TDATA_BITS = ((glp_pkg::REC_FIXED_BITS + COUNT_BITS + 7) / 8) * 8;
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};
  localparam int RANDOM_BYTES = 1700;
  localparam int HOLD_CYCLES = 300;
  localparam int WATCHDOG_CYCLES = 2000;
  localparam int DRAIN_CYCLES = 16;

  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_COMMA = 8'h2C;

  typedef enum logic [3:0] {
    LOOK_R, LOOK_S, LOOK_DIGIT, IN_RS, SEEK_CHROM, CHROM_TWO,
    SEEK_POS, IN_POS, SEEK_ALLELE1, SEEK_ALLELE2, LINE_DONE
  } scan_t;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } text_byte_t;

  // matches the m_tdata layout, rs_number in the lowest bits
  typedef struct packed {
    logic [TDATA_BITS-glp_pkg::REC_FIXED_BITS-COUNT_BITS-1:0] pad;
    logic [COUNT_BITS-1:0]         idx;
    logic [7:0]                    al2;
    logic [7:0]                    al1;
    logic [glp_pkg::NUM_BITS-1:0]  pos;
    logic [7:0]                    ch2;
    logic [7:0]                    ch1;
    logic [glp_pkg::NUM_BITS-1:0]  rs;
  } genotype_rec_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [7:0]            s_tdata = 8'h00;
  logic                  s_tlast = 1'b0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [TDATA_BITS-1:0] m_tdata;

  genotype_line_parser_unit #(
    .LINE_BYTES(LINE_BYTES),
    .COUNT_BITS(COUNT_BITS)
  ) i_dut (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .s_tlast (s_tlast),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  text_byte_t    text_q[$];
  logic [7:0]    line_buf[$];
  genotype_rec_t rec_q[$];

  // line scanner state
  scan_t                        scan;
  int unsigned                  line_pos;
  bit                           qualifies;
  logic [glp_pkg::NUM_BITS-1:0] rs_val;
  logic [7:0]                   chrom1, chrom2;
  logic [glp_pkg::NUM_BITS-1:0] pos_val;
  logic [7:0]                   allele1, allele2;
  logic [COUNT_BITS-1:0]        rec_count;

  int tx_gap, tx_run, rx_gap, rx_run, hold_left;
  bit tx_calm, rx_calm, hold_done;
  int quiet;
  int mismatches, records_seen, records_made, lines_built, long_lines, saturated;
  int in_stalls;

  function automatic bit is_digit(input logic [7:0] c);
    return c >= glp_pkg::CH_ZERO && c <= glp_pkg::CH_NINE;
  endfunction

  function automatic bit is_allele(input logic [7:0] c);
    return c == glp_pkg::CH_A || c == glp_pkg::CH_C || c == glp_pkg::CH_G ||
           c == glp_pkg::CH_T || c == glp_pkg::CH_D || c == glp_pkg::CH_I ||
           c == glp_pkg::CH_ZERO;
  endfunction

  function automatic logic [glp_pkg::NUM_BITS-1:0] dec_step(
      input logic [glp_pkg::NUM_BITS-1:0] v, input logic [7:0] c);
    logic [63:0] n;
    n = 64'(v) * 64'd10 + 64'(c - glp_pkg::CH_ZERO);
    return (n > 64'(glp_pkg::NUM_MAX)) ? glp_pkg::NUM_MAX : n[glp_pkg::NUM_BITS-1:0];
  endfunction

  function automatic int draw_gap(inout int run, inout bit calm);
    if (run == 0) begin
      run = $urandom_range(10, 80);
      calm = ($urandom_range(0, 3) == 0);
    end
    run--;
    return calm ? 0 : $urandom_range(0, 14);
  endfunction

  task automatic clear_line();
    scan = LOOK_R;
    line_pos = 0;
    qualifies = 1'b0;
    rs_val = '0;
    chrom1 = 8'h00;
    chrom2 = 8'h00;
    pos_val = '0;
    allele1 = 8'h00;
    allele2 = 8'h00;
  endtask

  task automatic chrom_try(input logic [7:0] c);
    if (is_digit(c)) begin
      chrom1 = c;
      scan = CHROM_TWO;
    end else if (c == glp_pkg::CH_X_UP || c == glp_pkg::CH_X_LO) begin
      chrom1 = glp_pkg::CH_X_UP;
      scan = SEEK_POS;
    end else if (c == glp_pkg::CH_Y_UP || c == glp_pkg::CH_Y_LO) begin
      chrom1 = glp_pkg::CH_Y_UP;
      scan = SEEK_POS;
    end
  endtask

  task automatic allele_try(input logic [7:0] c);
    if (is_allele(c)) begin
      allele1 = c;
      scan = SEEK_ALLELE2;
    end
  endtask

  task automatic scan_char(input logic [7:0] c);
    case (scan)
      LOOK_R: scan = (c == glp_pkg::CH_R) ? LOOK_S : LINE_DONE;
      LOOK_S: scan = (c == glp_pkg::CH_S) ? LOOK_DIGIT : LINE_DONE;
      LOOK_DIGIT: begin
        if (is_digit(c)) begin
          qualifies = 1'b1;
          rs_val = dec_step('0, c);
          scan = IN_RS;
        end else begin
          scan = LINE_DONE;
        end
      end
      IN_RS: begin
        if (is_digit(c)) begin
          rs_val = dec_step(rs_val, c);
        end else begin
          scan = SEEK_CHROM;
          chrom_try(c);
        end
      end
      SEEK_CHROM: chrom_try(c);
      CHROM_TWO: begin
        if (is_digit(c)) chrom2 = c;
        scan = SEEK_POS;
      end
      SEEK_POS: begin
        if (is_digit(c)) begin
          pos_val = dec_step('0, c);
          scan = IN_POS;
        end
      end
      IN_POS: begin
        if (is_digit(c)) begin
          pos_val = dec_step(pos_val, c);
        end else begin
          scan = SEEK_ALLELE1;
          allele_try(c);
        end
      end
      SEEK_ALLELE1: allele_try(c);
      SEEK_ALLELE2: begin
        if (is_allele(c)) begin
          allele2 = c;
          scan = LINE_DONE;
        end
      end
      default: ;
    endcase
  endtask

  task automatic take_byte(input logic [7:0] c, input logic last);
    genotype_rec_t r;
    if (line_pos < LINE_BYTES) begin
      scan_char(c);
      line_pos++;
    end
    if (last) begin
      if (qualifies) begin
        if (rec_count < COUNT_MAX) rec_count++;
        r.pad = '0;
        r.idx = rec_count;
        r.al2 = allele2;
        r.al1 = allele1;
        r.pos = pos_val;
        r.ch2 = chrom2;
        r.ch1 = chrom1;
        r.rs  = rs_val;
        rec_q.push_back(r);
        records_made++;
        if (rs_val == glp_pkg::NUM_MAX || pos_val == glp_pkg::NUM_MAX) saturated++;
      end
      clear_line();
    end
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      if (mismatches < 10) begin
        $display("%0t record %0d %s: expected %0d, got %0d",
                 $time, records_seen, name, want, got);
      end
      mismatches++;
    end
  endtask

  task automatic check_record(input genotype_rec_t got);
    genotype_rec_t want;
    if (rec_q.size() == 0) begin
      if (mismatches < 10) begin
        $display("%0t unexpected record: rs %0d index %0d", $time, got.rs, got.idx);
      end
      mismatches++;
    end else begin
      want = rec_q.pop_front();
      check_field("rs_number", 32'(want.rs), 32'(got.rs));
      check_field("chrom_first", 32'(want.ch1), 32'(got.ch1));
      check_field("chrom_second", 32'(want.ch2), 32'(got.ch2));
      check_field("position", 32'(want.pos), 32'(got.pos));
      check_field("allele_first", 32'(want.al1), 32'(got.al1));
      check_field("allele_second", 32'(want.al2), 32'(got.al2));
      check_field("record_index", 32'(want.idx), 32'(got.idx));
      check_field("zero fill", 32'(want.pad), 32'(got.pad));
    end
    records_seen++;
  endtask

  // line building
  task automatic flush_line();
    text_byte_t t;
    if (line_buf.size() == 0) line_buf.push_back(8'($urandom_range(0, 255)));
    foreach (line_buf[i]) begin
      t.ch = line_buf[i];
      t.last = (i == line_buf.size() - 1);
      text_q.push_back(t);
    end
    lines_built++;
    if (line_buf.size() > LINE_BYTES) long_lines++;
    line_buf.delete();
  endtask

  task automatic add_text(input string s);
    for (int i = 0; i < s.len(); i++) line_buf.push_back(s[i]);
  endtask

  task automatic add_digits(input int n);
    repeat (n) line_buf.push_back(glp_pkg::CH_ZERO + 8'($urandom_range(0, 9)));
  endtask

  task automatic add_number();
    add_digits(($urandom_range(0, 9) == 0) ? $urandom_range(10, 12) : $urandom_range(1, 9));
  endtask

  function automatic logic [7:0] non_digit();
    logic [7:0] b;
    do b = 8'($urandom_range(0, 255)); while (is_digit(b));
    return b;
  endfunction

  task automatic add_sep();
    repeat ($urandom_range(1, 3)) begin
      case ($urandom_range(0, 3))
        0: line_buf.push_back(CH_TAB);
        1: line_buf.push_back(CH_SPACE);
        2: line_buf.push_back(CH_COMMA);
        default: line_buf.push_back(non_digit());
      endcase
    end
  endtask

  task automatic add_allele();
    case ($urandom_range(0, 7))
      0: line_buf.push_back(glp_pkg::CH_A);
      1: line_buf.push_back(glp_pkg::CH_C);
      2: line_buf.push_back(glp_pkg::CH_G);
      3: line_buf.push_back(glp_pkg::CH_T);
      4: line_buf.push_back(glp_pkg::CH_D);
      5: line_buf.push_back(glp_pkg::CH_I);
      6: line_buf.push_back(glp_pkg::CH_ZERO);
      default: line_buf.push_back(non_digit());
    endcase
  endtask

  task automatic build_record_line(input bit stretch);
    int n;
    line_buf.push_back(glp_pkg::CH_R);
    line_buf.push_back(glp_pkg::CH_S);
    add_number();
    add_sep();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: add_digits(1);
      4, 5: add_digits(2);
      6: add_digits(3);
      7: line_buf.push_back($urandom_range(0, 1) ? glp_pkg::CH_X_UP : glp_pkg::CH_X_LO);
      8: line_buf.push_back($urandom_range(0, 1) ? glp_pkg::CH_Y_UP : glp_pkg::CH_Y_LO);
      default: line_buf.push_back(non_digit());
    endcase
    add_sep();
    add_number();
    add_sep();
    add_allele();
    add_sep();
    add_allele();
    repeat ($urandom_range(0, 4)) line_buf.push_back(8'($urandom_range(0, 255)));
    if (stretch) begin
      n = $urandom_range(LINE_BYTES - 6, LINE_BYTES + 44);
      while (line_buf.size() < n) line_buf.push_back(8'($urandom_range(0, 255)));
    end else if ($urandom_range(0, 5) == 0) begin
      // cut short so trailing fields go missing
      n = $urandom_range(3, line_buf.size());
      while (line_buf.size() > n) void'(line_buf.pop_back());
    end
    flush_line();
  endtask

  // sender
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
      s_tdata <= 8'h00;
      s_tlast <= 1'b0;
      tx_gap = 0;
      clear_line();
      rec_count = '0;
    end else begin
      if (s_tvalid && !s_tready) in_stalls++;
      if (s_tvalid && s_tready) begin
        take_byte(s_tdata, s_tlast);
        void'(text_q.pop_front());
        tx_gap = (hold_left > 0) ? 0 : draw_gap(tx_run, tx_calm);
      end
      if (s_tvalid && !s_tready) begin
        // keep offering the same item
      end else if (tx_gap > 0) begin
        tx_gap--;
        s_tvalid <= 1'b0;
      end else if (text_q.size() != 0) begin
        s_tvalid <= 1'b1;
        s_tdata <= text_q[0].ch;
        s_tlast <= text_q[0].last;
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // receiver
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
      rx_gap = 0;
      hold_left = 0;
    end else begin
      if (m_tvalid && m_tready) begin
        check_record(genotype_rec_t'(m_tdata));
        rx_gap = draw_gap(rx_run, rx_calm);
        if (records_seen == 6 && !hold_done) begin
          hold_left = HOLD_CYCLES;
          hold_done = 1'b1;
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else if (rx_gap > 0) begin
        rx_gap--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet <= 0;
    end else if (quiet >= WATCHDOG_CYCLES) begin
      $display("watchdog: no item moved for %0d cycles", quiet);
      $display("genotype_line_parser_unit_tb NOT OK");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  initial begin
    // directed lines
    add_text("rs12x5GT");
    flush_line();
    line_buf.push_back(glp_pkg::CH_R);
    line_buf.push_back(8'hFF);
    flush_line();
    line_buf.push_back(8'h00);
    flush_line();
    add_text("rs0");
    flush_line();
    add_text("rs5 1234 0");
    flush_line();

    // random lines, the first one stretched to at least LINE_BYTES-6 bytes, so it can run past the parse window
    build_record_line(1'b1);
    while (text_q.size() < RANDOM_BYTES) begin
      case ($urandom_range(0, 99)) inside
        [0:2]: build_record_line(1'b1);
        [3:79]: build_record_line(1'b0);
        [80:91]: begin
          repeat ($urandom_range(1, 20)) line_buf.push_back(8'($urandom_range(0, 255)));
          flush_line();
        end
        default: begin
          line_buf.push_back(glp_pkg::CH_R);
          if ($urandom_range(0, 1)) begin
            line_buf.push_back(glp_pkg::CH_S);
            line_buf.push_back(non_digit());
          end else begin
            do line_buf.push_back(8'($urandom_range(0, 255)));
            while (line_buf[1] == glp_pkg::CH_S && line_buf.pop_back() == glp_pkg::CH_S);
          end
          repeat ($urandom_range(0, 8)) line_buf.push_back(8'($urandom_range(0, 255)));
          flush_line();
        end
      endcase
    end

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    while (text_q.size() != 0 || rec_q.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    $display("%0d lines (%0d past the %0d-byte window), %0d records checked",
             lines_built, long_lines, LINE_BYTES, records_seen);
    $display("%0d records with a saturated number, %0d input stall cycles",
             saturated, in_stalls);
    if (mismatches == 0 && rec_q.size() == 0 && records_seen == records_made) begin
      $display("genotype_line_parser_unit_tb OK");
    end else begin
      $display("genotype_line_parser_unit_tb NOT OK");
    end
    $finish;
  end

endmodule
`default_nettype wire
